>>> sv/pcx_row_rle_planar_decoder_top_macros.svh
// Assertion helpers used by the decoder back end.
`ifndef PCX_ROW_RLE_PLANAR_DECODER_TOP_MACROS_SVH
`define PCX_ROW_RLE_PLANAR_DECODER_TOP_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define PCXRLE_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define PCXRLE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> sv/pcxrle_pkg.sv
package pcxrle_pkg;

  localparam int unsigned ROW_BUFFER_BYTES_DEF = 32768;
  localparam int unsigned MAX_WIDTH_DEF        = 8192;
  localparam int unsigned PALETTE_ENTRIES      = 256;
  // plane offset plus byte offset: 15 * 65535 + 8191 fits in 21 bits
  localparam int unsigned RD_AW                = 21;

  localparam logic [7:0] RUN_MARK     = 8'hC0;
  localparam logic [7:0] RUN_CNT_MASK = 8'h3F;

  typedef enum logic [1:0] {
    OP_PAL  = 2'd0,
    OP_DATA = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_PIXEL = 2'd0,
    ST_ROW   = 2'd1,
    ST_ERR   = 2'd2,
    ST_WAIT  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_BITS   = 3'd0,
    CFG_PLANES = 3'd1,
    CFG_BPL    = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_rgb;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic [12:0] pixel_x;
    logic [15:0] pixel_y;
    logic        last_in_row;
    logic        last_of_image;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e         kind;
    logic        run_mark;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_rgb;
  } cmd_t;

  // decoded configuration
  typedef struct packed {
    logic        ok;
    logic [1:0]  lg;
    logic [3:0]  b;
    logic [7:0]  bmask;
    logic [3:0]  planes;
    logic [15:0] bpl;
    logic [19:0] n;
    logic [13:0] width;
    logic [16:0] height;
    logic        pal_mode;
    logic        alpha;
  } cfg_t;

endpackage

>>> sv/pcx_row_rle_planar_decoder_top.sv
// PCX row decoder. Load palette entries (op 0), stream run-length coded bytes
// (op 1) until a row of bytes_per_line * plane_count bytes is complete, then
// issue one read (op 2) per pixel. A literal byte is written to the row store
// as its beat is taken; the value byte of a run of count c is written max(c, 1)
// times through the row store's single write port. A pixel read issues one
// row-store read per plane, then a palette lookup in indexed modes, before its
// result enters the output register. The engine takes the next beat only after
// the current one is done. A two-entry queue separates the input side from the
// decode engine. Errors stay set until reset; row and palette contents are not
// cleared by reset.
module pcx_row_rle_planar_decoder_top #(
  parameter int unsigned ROW_BUFFER_BYTES = pcxrle_pkg::ROW_BUFFER_BYTES_DEF,
  parameter int unsigned MAX_WIDTH        = pcxrle_pkg::MAX_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  pcxrle_pkg::in_item_t   in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output pcxrle_pkg::out_item_t  out_item_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);
  import pcxrle_pkg::*;

  logic [3:0]  bits_q, planes_q;
  logic [15:0] bpl_q;
  logic [13:0] width_q;
  logic [16:0] height_q;
  cfg_t        cfg_q, cfg_d;
  logic [7:0]  total;
  logic        b_ok, tot_ok;
  logic        q_push, q_ready, q_valid, q_pop;
  cmd_t        q_in, q_out;

  assign cfg_ready_o = 1'b1;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q   <= 4'd8;
      planes_q <= 4'd1;
      bpl_q    <= 16'd1;
      width_q  <= 14'd1;
      height_q <= 17'd1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BITS:   bits_q   <= cfg_data_i[3:0];
        CFG_PLANES: planes_q <= cfg_data_i[3:0];
        CFG_BPL:    bpl_q    <= cfg_data_i[15:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[13:0];
        CFG_HEIGHT: height_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // decode and validate configuration
  always_comb begin
    total  = {4'd0, bits_q} * {4'd0, planes_q};
    b_ok   = 1'b1;
    cfg_d  = '0;
    case (bits_q)
      4'd1:    cfg_d.lg = 2'd0;
      4'd2:    cfg_d.lg = 2'd1;
      4'd4:    cfg_d.lg = 2'd2;
      4'd8:    cfg_d.lg = 2'd3;
      default: b_ok = 1'b0;
    endcase
    tot_ok         = (total != 8'd0) && (total <= 8'd8 || total == 8'd24 || total == 8'd32);
    cfg_d.b        = bits_q;
    cfg_d.bmask    = 8'((9'd1 << bits_q) - 9'd1);
    cfg_d.planes   = planes_q;
    cfg_d.bpl      = bpl_q;
    cfg_d.n        = {4'd0, bpl_q} * {16'd0, planes_q};
    cfg_d.width    = width_q;
    cfg_d.height   = height_q;
    cfg_d.pal_mode = (total <= 8'd8);
    cfg_d.alpha    = (total == 8'd32);
    cfg_d.ok       = b_ok && tot_ok && (bpl_q != 16'd0) && (width_q != 14'd0) &&
                     (height_q != 17'd0) && ({3'd0, width_q} <= 17'(MAX_WIDTH)) &&
                     ({2'd0, 17'({3'd0, width_q}) << cfg_d.lg} <= {bpl_q, 3'b000}) &&
                     (cfg_d.n <= 20'(ROW_BUFFER_BYTES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pcxrle_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  pcxrle_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_out)
  );

  pcxrle_back #(
    .ROW_BUFFER_BYTES (ROW_BUFFER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );
endmodule

>>> sv/pcxrle_queue.sv
module pcxrle_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pcxrle_pkg::cmd_t  push_item_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pcxrle_pkg::cmd_t  item_o
);
  import pcxrle_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rp_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // advance pointers and fill count
  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // hold entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= push_item_i;
    end
  end
endmodule

>>> sv/pcxrle_front.sv
module pcxrle_front (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pcxrle_pkg::in_item_t  in_item_i,
  input  logic                  q_ready_i,
  output logic                  q_push_o,
  output pcxrle_pkg::cmd_t      q_item_o
);
  import pcxrle_pkg::*;

  op_e kind;

  // classify the beat; unused op codes are taken and dropped
  always_comb begin
    kind                   = op_e'(in_item_i.op);
    q_item_o.kind          = kind;
    q_item_o.run_mark      = (in_item_i.data_byte >= RUN_MARK);
    q_item_o.data_byte     = in_item_i.data_byte;
    q_item_o.palette_index = in_item_i.palette_index;
    q_item_o.palette_rgb   = in_item_i.palette_rgb;
  end

  assign in_stall_o = !q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i && (kind != OP_NONE);
endmodule

>>> sv/pcxrle_back.sv
`include "pcx_row_rle_planar_decoder_top_macros.svh"
module pcxrle_back #(
  parameter int unsigned ROW_BUFFER_BYTES = pcxrle_pkg::ROW_BUFFER_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pcxrle_pkg::cfg_t       cfg_i,
  input  logic                   q_valid_i,
  input  pcxrle_pkg::cmd_t       q_item_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output pcxrle_pkg::out_item_t  out_item_o
);
  import pcxrle_pkg::*;

  localparam int unsigned ROW_AW = $clog2(ROW_BUFFER_BYTES);
  localparam int unsigned FILL_W = $clog2(ROW_BUFFER_BYTES + 1);

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_RD, S_PAL, S_EMIT} state_e;

  state_e              state_q, state_d;
  logic [FILL_W-1:0]   fill_q, fill_d, run_end_q, run_end_d;
  logic                run_pend_q, run_pend_d, row_ready_q, row_ready_d;
  logic [13:0]         col_q, col_d;
  logic [16:0]         row_q, row_d;
  logic                err_q, err_d, done_q, done_d;
  logic [7:0]          run_byte_q, run_byte_d;
  out_item_t           res_q, res_d, out_q, out_d;
  logic                out_vld_q, out_vld_d;
  logic [RD_AW-1:0]    rd_addr_q, rd_addr_d;
  logic [3:0]          iss_q, iss_d, got_q, got_d;
  logic                pend_q, pend_d, oob_q, oob_d;
  logic [2:0]          bsh_q, bsh_d;
  logic [5:0]          acc_q, acc_d;
  logic [31:0]         val_q, val_d;

  logic [7:0]          row_mem [ROW_BUFFER_BYTES];
  logic [23:0]         pal_mem [PALETTE_ENTRIES];
  logic [7:0]          row_rd_q;
  logic [23:0]         pal_rd_q;
  logic                row_we, pal_we;
  logic [ROW_AW-1:0]   row_wa;
  logic [7:0]          row_wd;
  logic [7:0]          pal_ra;

  logic                out_free;
  logic [19:0]         nf;
  logic [5:0]          cnt;
  logic [16:0]         bitpos;
  logic [3:0]          sh4;
  logic [7:0]          byte_v, pix;
  logic [31:0]         val_nx, pix_val;
  logic                pix_done, last_col, last_row;

  function automatic out_item_t mk_status(status_e st);
    out_item_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  assign out_free    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // gather one plane byte per cycle
  always_comb begin
    byte_v = oob_q ? 8'd0 : row_rd_q;
    pix    = (byte_v >> bsh_q) & cfg_i.bmask;
    val_nx = val_q | (32'(pix) << acc_q);
    bitpos = 17'(col_q) << cfg_i.lg;
    sh4    = 4'd8 - cfg_i.b - {1'b0, bitpos[2:0]};
    cnt    = q_item_i.data_byte[5:0] & RUN_CNT_MASK[5:0];
    pal_ra = val_nx[7:0];
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    run_end_d   = run_end_q;
    run_pend_d  = run_pend_q;
    row_ready_d = row_ready_q;
    col_d       = col_q;
    row_d       = row_q;
    err_d       = err_q;
    done_d      = done_q;
    run_byte_d  = run_byte_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && out_stall_i;
    rd_addr_d   = rd_addr_q;
    iss_d       = iss_q;
    got_d       = got_q;
    pend_d      = 1'b0;
    oob_d       = oob_q;
    bsh_d       = bsh_q;
    acc_d       = acc_q;
    val_d       = val_q;
    q_pop_o     = 1'b0;
    row_we      = 1'b0;
    row_wa      = fill_q[ROW_AW-1:0];
    row_wd      = q_item_i.data_byte;
    pal_we      = 1'b0;
    nf          = 20'(fill_q) + 20'd1;
    pix_done    = 1'b0;
    pix_val     = val_nx;
    last_col    = (15'(col_q) + 15'd1) >= 15'(cfg_i.width);
    last_row    = (18'(row_q) + 18'd1) >= 18'(cfg_i.height);

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.kind == OP_PAL) begin
            pal_we = 1'b1;
          end else if (err_q) begin
            res_d = mk_status(ST_ERR); state_d = S_EMIT;
          end else if (done_q) begin
            res_d = mk_status(ST_WAIT); state_d = S_EMIT;
          end else if (!cfg_i.ok) begin
            err_d = 1'b1; res_d = mk_status(ST_ERR); state_d = S_EMIT;
          end else if (q_item_i.kind == OP_DATA) begin
            if (row_ready_q) begin
              res_d = mk_status(ST_WAIT); state_d = S_EMIT;
            end else if (20'(fill_q) >= cfg_i.n ||
                         (run_pend_q && 20'(run_end_q) >= cfg_i.n)) begin
              err_d = 1'b1; res_d = mk_status(ST_ERR); state_d = S_EMIT;
            end else if (run_pend_q) begin
              run_byte_d = q_item_i.data_byte;
              state_d    = S_RUN;
            end else if (q_item_i.run_mark) begin
              // open a run; the value comes with the next byte
              if (20'(fill_q) + 20'(cnt) > cfg_i.n) begin
                err_d = 1'b1; res_d = mk_status(ST_ERR); state_d = S_EMIT;
              end else begin
                run_end_d  = FILL_W'(20'(fill_q) + ((cnt != 6'd0) ? 20'(cnt) - 20'd1 : 20'd0));
                run_pend_d = 1'b1;
              end
            end else begin
              // literal byte
              row_we = 1'b1;
              if (nf >= cfg_i.n) begin
                row_ready_d = 1'b1; fill_d = '0; col_d = '0;
                res_d = mk_status(ST_ROW); state_d = S_EMIT;
              end else begin
                fill_d = FILL_W'(nf);
              end
            end
          end else if (!row_ready_q) begin
            res_d = mk_status(ST_WAIT); state_d = S_EMIT;
          end else begin
            // start pixel gather
            rd_addr_d = RD_AW'(bitpos[16:3]);
            bsh_d     = sh4[2:0];
            iss_d     = '0;
            got_d     = '0;
            acc_d     = '0;
            val_d     = '0;
            state_d   = S_RD;
          end
        end
      end
      S_RUN: begin
        row_we = 1'b1;
        row_wd = run_byte_q;
        if (fill_q == run_end_q) begin
          nf         = 20'(run_end_q) + 20'd1;
          run_pend_d = 1'b0;
          if (nf >= cfg_i.n) begin
            row_ready_d = 1'b1; fill_d = '0; col_d = '0;
            res_d = mk_status(ST_ROW); state_d = S_EMIT;
          end else begin
            fill_d  = FILL_W'(nf);
            state_d = S_IDLE;
          end
        end else begin
          fill_d = fill_q + FILL_W'(1);
        end
      end
      S_RD: begin
        if (iss_q < cfg_i.planes) begin
          pend_d    = 1'b1;
          oob_d     = rd_addr_q >= RD_AW'(ROW_BUFFER_BYTES);
          rd_addr_d = rd_addr_q + RD_AW'(cfg_i.bpl);
          iss_d     = iss_q + 4'd1;
        end
        if (pend_q) begin
          val_d = val_nx;
          acc_d = acc_q + 6'(cfg_i.b);
          got_d = got_q + 4'd1;
          if (got_q + 4'd1 == cfg_i.planes) begin
            if (cfg_i.pal_mode) begin
              state_d = S_PAL;
            end else begin
              pix_done = 1'b1;
            end
          end
        end
      end
      S_PAL: begin
        pix_val  = {8'd0, pal_rd_q};
        pix_done = 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // finish a pixel and step the counters
    if (pix_done) begin
      res_d.status        = ST_PIXEL;
      res_d.red           = pix_val[7:0];
      res_d.green         = pix_val[15:8];
      res_d.blue          = pix_val[23:16];
      res_d.alpha         = cfg_i.alpha ? pix_val[31:24] : 8'd0;
      res_d.has_alpha     = cfg_i.alpha;
      res_d.pixel_x       = col_q[12:0];
      res_d.pixel_y       = row_q[15:0];
      res_d.last_in_row   = last_col;
      res_d.last_of_image = last_col && last_row;
      if (last_col) begin
        row_ready_d = 1'b0;
        col_d       = '0;
        if (last_row) begin
          done_d = 1'b1;
        end else begin
          row_d = row_q + 17'd1;
        end
      end else begin
        col_d = col_q + 14'd1;
      end
      state_d = S_EMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      run_end_q   <= '0;
      run_pend_q  <= 1'b0;
      row_ready_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      err_q       <= 1'b0;
      done_q      <= 1'b0;
      out_vld_q   <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      run_end_q   <= run_end_d;
      run_pend_q  <= run_pend_d;
      row_ready_q <= row_ready_d;
      col_q       <= col_d;
      row_q       <= row_d;
      err_q       <= err_d;
      done_q      <= done_d;
      out_vld_q   <= out_vld_d;
      pend_q      <= pend_d;
    end
  end

  // hold datapath registers
  always_ff @(posedge clk_i) begin
    run_byte_q <= run_byte_d;
    res_q      <= res_d;
    out_q      <= out_d;
    rd_addr_q  <= rd_addr_d;
    iss_q      <= iss_d;
    got_q      <= got_d;
    oob_q      <= oob_d;
    bsh_q      <= bsh_d;
    acc_q      <= acc_d;
    val_q      <= val_d;
  end

  // row store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    row_rd_q <= row_mem[rd_addr_q[ROW_AW-1:0]];
  end

  // palette store
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[q_item_i.palette_index] <= q_item_i.palette_rgb;
    end
    pal_rd_q <= pal_mem[pal_ra];
  end

  `PCXRLE_ASSERT_NOW(a_ready_fill, row_ready_q, fill_q == '0, "fill position set while row ready")
  `PCXRLE_ASSERT_NOW(a_run_bound, state_q == S_RUN, run_pend_q && fill_q <= run_end_q, "run beyond its end")
  `PCXRLE_ASSERT_NEXT(a_err_sticky, err_q, err_q, "error flag cleared")
endmodule

>>> tb/sv/tb.sv
module tb;
  import pcxrle_pkg::*;

  localparam int unsigned ROW_BYTES   = 32768;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE      = 300;

  typedef struct {
    in_item_t  item;
    bit        has_res;
    out_item_t res;
  } beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  pcx_row_rle_planar_decoder_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // decoder image: stores, counters and registers
  logic [7:0]  row_mem [ROW_BYTES];
  logic [23:0] pal_mem [256];
  bit          pal_seen [256];
  int unsigned fill_pos, run_last, col_pos, row_pos;
  bit          run_open, row_full, err_seen, img_done;
  int unsigned r_bits = 8, r_planes = 1, r_bpl = 1, r_width = 1, r_height = 1;

  beat_t       pending_beats[$];
  out_item_t   expected_pixels[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0, out_hold = 0;
  bit          quiet = 0;
  int unsigned data_items = 0;

  always #6 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit cfg_good();
    int unsigned t;
    t = r_bits * r_planes;
    if (!(r_bits inside {1, 2, 4, 8})) return 0;
    if (r_planes == 0 || r_bpl == 0 || r_width == 0 || r_height == 0) return 0;
    if (!(t <= 8 || t == 24 || t == 32)) return 0;
    if (r_width > MAX_WIDTH_DEF) return 0;
    if (r_bpl * 8 < r_width * r_bits) return 0;
    if (r_bpl * r_planes > ROW_BYTES) return 0;
    return 1;
  endfunction

  // gather plane bits of one column, plane 0 lowest
  function automatic int unsigned gather_pixel(int unsigned x);
    int unsigned v, bp, sh, pos, byt;
    v = 0;
    for (int unsigned i = 0; i < r_planes; i++) begin
      bp = x * r_bits;
      sh = 8 - r_bits - (bp & 7);
      pos = i * r_bpl + (bp >> 3);
      byt = pos < ROW_BYTES ? row_mem[pos] : 0;
      v |= ((byt >> sh) & ((1 << r_bits) - 1)) << (i * r_bits);
    end
    return v;
  endfunction

  function automatic void decode_predict(input in_item_t it, output bit has,
                                         output out_item_t r);
    int unsigned n, d, cnt, v, t;
    r = '0;
    has = 0;
    if (it.op == OP_PAL) begin
      pal_mem[it.palette_index] = it.palette_rgb;
      pal_seen[it.palette_index] = 1;
      return;
    end
    if (it.op == OP_NONE) return;
    has = 1;
    if (err_seen) begin r.status = ST_ERR; return; end
    if (img_done) begin r.status = ST_WAIT; return; end
    if (!cfg_good()) begin err_seen = 1; r.status = ST_ERR; return; end
    if (it.op == OP_DATA) begin
      if (row_full) begin r.status = ST_WAIT; return; end
      n = r_bpl * r_planes;
      d = it.data_byte;
      if (fill_pos >= n || (run_open && run_last >= n)) begin
        err_seen = 1; r.status = ST_ERR; return;
      end
      if (run_open) begin
        for (int unsigned p = fill_pos; p <= run_last; p++)
          if (p < ROW_BYTES) row_mem[p] = d[7:0];
        fill_pos = run_last + 1;
        run_open = 0;
      end else if (d >= RUN_MARK) begin
        cnt = d & RUN_CNT_MASK;
        if (fill_pos + cnt > n) begin err_seen = 1; r.status = ST_ERR; return; end
        run_last = fill_pos + (cnt != 0 ? cnt - 1 : 0);
        run_open = 1;
        has = 0;
        return;
      end else begin
        if (fill_pos < ROW_BYTES) row_mem[fill_pos] = d[7:0];
        fill_pos++;
      end
      if (fill_pos >= n) begin
        row_full = 1; fill_pos = 0; col_pos = 0;
        r.status = ST_ROW;
      end else has = 0;
      return;
    end
    if (!row_full) begin r.status = ST_WAIT; return; end
    t = r_bits * r_planes;
    v = gather_pixel(col_pos);
    if (t <= 8) v = pal_mem[v & 8'hFF];
    r.status    = ST_PIXEL;
    r.red       = v[7:0];
    r.green     = v[15:8];
    r.blue      = v[23:16];
    r.alpha     = t == 32 ? v[31:24] : 8'h00;
    r.has_alpha = t == 32;
    r.pixel_x   = col_pos[12:0];
    r.pixel_y   = row_pos[15:0];
    if (col_pos + 1 >= r_width) begin
      r.last_in_row = 1;
      row_full = 0;
      col_pos = 0;
      if (row_pos + 1 >= r_height) begin
        img_done = 1; r.last_of_image = 1;
      end else row_pos++;
    end else col_pos++;
  endfunction

  task automatic push_item(input in_item_t it);
    beat_t b;
    b.item = it;
    decode_predict(it, b.has_res, b.res);
    pending_beats.push_back(b);
    data_items++;
  endtask

  task automatic push_op(input op_e op, input int unsigned d);
    in_item_t it;
    it.op = op;
    it.data_byte = d[7:0];
    it.palette_index = $urandom_range(0, 255);
    it.palette_rgb = $urandom_range(0, 24'hFFFFFF);
    push_item(it);
  endtask

  task automatic push_pal(input int unsigned idx, input int unsigned rgb);
    in_item_t it;
    it.op = OP_PAL;
    it.data_byte = $urandom_range(0, 255);
    it.palette_index = idx[7:0];
    it.palette_rgb = rgb[23:0];
    push_item(it);
  endtask

  // read out the finished row, loading any palette entry it needs first
  task automatic drain_row();
    int unsigned idx;
    while (row_full) begin
      if ($urandom_range(0, 99) < 4) push_op(OP_DATA, $urandom_range(0, 255));
      if (r_bits * r_planes <= 8) begin
        idx = gather_pixel(col_pos) & 8'hFF;
        if (!pal_seen[idx] || $urandom_range(0, 99) < 3)
          push_pal(idx, $urandom_range(0, 24'hFFFFFF));
      end
      push_op(OP_READ, $urandom_range(0, 255));
    end
  endtask

  // stream one coded row, then read it out
  task automatic code_row(input bit long_runs);
    int unsigned n, rem, cnt, r;
    n = r_bpl * r_planes;
    while (!row_full) begin
      r = $urandom_range(0, 99);
      if (r < 3) push_op(OP_NONE, $urandom_range(0, 255));
      else if (r < 6) push_op(OP_READ, $urandom_range(0, 255));
      else if (r < 9) push_pal($urandom_range(0, 255), $urandom_range(0, 24'hFFFFFF));
      rem = n - fill_pos;
      if (long_runs || $urandom_range(0, 1)) begin
        cnt = rem < 63 ? rem : 63;
        if (!long_runs) cnt = $urandom_range(0, cnt);
        push_op(OP_DATA, RUN_MARK | cnt);
        push_op(OP_DATA, $urandom_range(0, 255));
      end else push_op(OP_DATA, $urandom_range(0, 8'hBF));
    end
    drain_row();
  endtask

  task automatic reg_write(input cfg_idx_e idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_BITS:   r_bits   = val & 32'hF;
      CFG_PLANES: r_planes = val & 32'hF;
      CFG_BPL:    r_bpl    = val & 32'hFFFF;
      CFG_WIDTH:  r_width  = val & 32'h3FFF;
      default:    r_height = val & 32'h1FFFF;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_format(input int unsigned b, input int unsigned p,
                            input int unsigned w, input int unsigned bpl);
    reg_write(CFG_BITS, b);
    reg_write(CFG_PLANES, p);
    reg_write(CFG_WIDTH, w);
    reg_write(CFG_BPL, bpl);
  endtask

  // driver: present queued beats with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o && pending_beats[0].has_res)
        expected_pixels.push_back(pending_beats[0].res);
      if (in_valid_i && !in_stall_o) void'(pending_beats.pop_front());
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap != 0) begin
          in_gap     <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if ((in_valid_i && !in_stall_o ? pending_beats.size() > 0 :
                      pending_beats.size() > 0)) begin
          in_item_i  <= pending_beats[0].item;
          in_valid_i <= 1'b1;
          in_gap     <= pick_gap();
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: stall at random, compare each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item_o);
        end else begin
          if (out_item_o !== expected_pixels[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", expected_pixels[0], out_item_o);
          end
          void'(expected_pixels.pop_front());
        end
      end
      if (out_hold != 0) begin
        out_hold    <= out_hold - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_hold    <= pick_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned b, p, w, sel, rows;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_write(CFG_HEIGHT, 65536);
    set_format(8, 1, 2, 2);

    // directed: palette extremes, unused op, early read, zero-count run,
    // data while the row is ready
    push_pal(0, 0);
    push_pal(255, 24'hFFFFFF);
    push_op(OP_NONE, 8'hFF);
    push_op(OP_READ, 0);
    push_op(OP_DATA, RUN_MARK);
    push_op(OP_DATA, 8'hFF);
    push_op(OP_DATA, 8'h00);
    push_op(OP_DATA, 8'hBF);
    push_op(OP_READ, 0);
    push_op(OP_READ, 0);
    wait_idle();

    // widest planes with 1-bit pixels, then 32-bit direct color
    set_format(1, 8, 13, 2);
    code_row(0);
    wait_idle();
    set_format(8, 4, 3, 3);
    code_row(0);
    wait_idle();

    // largest row buffer, a single pixel
    set_format(8, 1, 1, ROW_BYTES);
    code_row(1);
    wait_idle();

    // random formats
    while (data_items < 1500) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: begin b = 1; p = $urandom_range(1, 8); end
        1: begin b = 2; p = $urandom_range(1, 4); end
        2: begin b = 4; p = $urandom_range(1, 2); end
        3: begin b = 8; p = 1; end
        4: begin b = 8; p = 3; end
        default: begin b = 8; p = 4; end
      endcase
      w = $urandom_range(0, 9) == 0 ? $urandom_range(40, 200) : $urandom_range(1, 16);
      quiet = $urandom_range(0, 4) == 0;
      set_format(b, p, w, (w * b + 7) / 8 + $urandom_range(0, 2));
      rows = $urandom_range(1, 3);
      repeat (rows) code_row(0);
      wait_idle();
    end

    // run past the row end, then the error sticks
    quiet = 0;
    set_format(8, 1, 4, 4);
    push_op(OP_DATA, RUN_MARK | 5);
    push_op(OP_DATA, 8'h12);
    push_op(OP_READ, 0);
    push_pal(7, 24'h123456);
    wait_idle();

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
